// ----- sv/lef_pkg.sv -----
// Shared constants and types of the 3x3 Laplacian edge filter.
package lef_pkg;

    // Defaults for the top-level parameters
    localparam int LINE_WIDTH_DEFAULT   = 1024;
    localparam int CHANNEL_BITS_DEFAULT = 8;

    // Configuration port layout
    localparam int CFG_INDEX_BITS  = 2;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_DATA_BITS   = 13;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

    // Frame geometry
    localparam int ROW_BITS      = 12;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int MIN_DIM       = 3;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    // Position of one item in the frame, as it matters for its results
    typedef struct packed {
        logic emit;      // item produces results at all
        logic border;    // first result is a border pixel (zero)
        logic last_col;  // item closes a row
        logic last_row;  // item lies in the final row
    } pos_flags_t;

endpackage

// ----- sv/lef_stream_if.sv -----
// Pixel and result stream interfaces of the 3x3 Laplacian edge filter.
interface lef_pixel_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface lef_result_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
    logic                    run_last;
    logic                    frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output run_last, output frame_end, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input run_last, input frame_end, output ready);
endinterface

// ----- sv/lef_line_mem.sv -----
// Line store memory: one write port, one registered read port.
module lef_line_mem #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 48
) (
    input  logic                                   clk,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_BITS-1:0]                   rd_data,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]                   wr_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the entry; hold the data while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/lef_window.sv -----
// 3x3 window registers and the Laplacian of the window centre.
module lef_window import lef_pkg::*; #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // item whose line store read has returned
    input  logic                      s1_valid,
    output logic                      s1_ready,
    input  logic [3*CHANNEL_BITS-1:0] s1_px,
    input  pos_flags_t                s1_flags,
    input  logic [3*CHANNEL_BITS-1:0] up_px,
    input  logic [3*CHANNEL_BITS-1:0] mid_px,
    // item handed on to the emitter
    output logic                      push_valid,
    input  logic                      push_ready,
    output logic [3*CHANNEL_BITS-1:0] push_value,
    output pos_flags_t                push_flags
);

    localparam int PXW      = 3 * CHANNEL_BITS;
    localparam int ACC_BITS = CHANNEL_BITS + 5;

    logic [PXW-1:0]             win_reg [9];
    logic                       w_valid_reg;
    pos_flags_t                 w_flags_reg;
    logic                       w_adv;
    logic                       s1_adv;
    logic [ACC_BITS-1:0]        ring_sum [3];
    logic signed [ACC_BITS-1:0] acc [3];
    logic [PXW-1:0]             lap_value;

    // Items without results drop out here; others wait for the emitter
    assign push_valid = w_valid_reg && w_flags_reg.emit;
    assign w_adv      = w_valid_reg && (push_ready || !w_flags_reg.emit);
    assign s1_ready   = !w_valid_reg || w_adv;
    assign s1_adv     = s1_valid && s1_ready;
    assign push_flags = w_flags_reg;
    assign push_value = w_flags_reg.border ? '0 : lap_value;

    // Hold the item slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            w_flags_reg <= '0;
        end
        else if (s1_adv)
        begin
            w_valid_reg <= 1'b1;
            w_flags_reg <= s1_flags;
        end
        else if (w_adv)
        begin
            w_valid_reg <= 1'b0;
        end
    end

    // Advance the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3]     <= win_reg[i*3 + 1];
                win_reg[i*3 + 1] <= win_reg[i*3 + 2];
            end
            win_reg[2] <= up_px;
            win_reg[5] <= mid_px;
            win_reg[8] <= s1_px;
        end
    end

    // Eight times the centre minus the neighbours, clamped per channel;
    // add the ring as a balanced tree
    always_comb
    begin
        lap_value = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            ring_sum[ch] =
                (({5'b00000, win_reg[0][ch*CHANNEL_BITS +: CHANNEL_BITS]}
                + {5'b00000, win_reg[1][ch*CHANNEL_BITS +: CHANNEL_BITS]})
               + ({5'b00000, win_reg[2][ch*CHANNEL_BITS +: CHANNEL_BITS]}
                + {5'b00000, win_reg[3][ch*CHANNEL_BITS +: CHANNEL_BITS]}))
              + (({5'b00000, win_reg[5][ch*CHANNEL_BITS +: CHANNEL_BITS]}
                + {5'b00000, win_reg[6][ch*CHANNEL_BITS +: CHANNEL_BITS]})
               + ({5'b00000, win_reg[7][ch*CHANNEL_BITS +: CHANNEL_BITS]}
                + {5'b00000, win_reg[8][ch*CHANNEL_BITS +: CHANNEL_BITS]}));
            acc[ch] = $signed({2'b00, win_reg[4][ch*CHANNEL_BITS +: CHANNEL_BITS], 3'b000})
                    - $signed(ring_sum[ch]);
            if (acc[ch] < 0)
            begin
                lap_value[ch*CHANNEL_BITS +: CHANNEL_BITS] = '0;
            end
            else if (acc[ch] > $signed({5'b00000, {CHANNEL_BITS{1'b1}}}))
            begin
                lap_value[ch*CHANNEL_BITS +: CHANNEL_BITS] = '1;
            end
            else
            begin
                lap_value[ch*CHANNEL_BITS +: CHANNEL_BITS] = acc[ch][CHANNEL_BITS-1:0];
            end
        end
    end

endmodule

// ----- sv/lef_emit.sv -----
// Result emitter: expands one item into its one to four results.
module lef_emit import lef_pkg::*; #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push_valid,
    output logic                      push_ready,
    input  logic [3*CHANNEL_BITS-1:0] push_value,
    input  pos_flags_t                push_flags,
    lef_result_if.source              result
);

    localparam int PXW = 3 * CHANNEL_BITS;

    logic           job_valid_reg;
    logic [1:0]     job_left_reg;
    logic           job_first_reg;
    logic           job_frame_reg;
    logic [PXW-1:0] job_value_reg;
    logic           out_valid_reg;
    logic [PXW-1:0] out_px_reg;
    logic           out_last_reg;
    logic           out_frame_reg;
    logic           out_load;
    logic           job_fire;
    logic           push_fire;
    logic [1:0]     push_left;

    assign out_load   = !out_valid_reg || result.ready;
    assign job_fire   = job_valid_reg && out_load;
    assign push_ready = !job_valid_reg || (out_load && job_left_reg == 2'd0);
    assign push_fire  = push_valid && push_ready;

    // Results after the first: one for the last row, one for the last column,
    // and one more when both hold
    always_comb
    begin
        unique case ({push_flags.last_row, push_flags.last_col})
            2'b11:   push_left = 2'd3;
            2'b10,
            2'b01:   push_left = 2'd1;
            default: push_left = 2'd0;
        endcase
    end

    // Hold the current item and count down its results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_left_reg  <= 2'd0;
            job_first_reg <= 1'b0;
            job_frame_reg <= 1'b0;
        end
        else if (push_fire)
        begin
            job_valid_reg <= 1'b1;
            job_left_reg  <= push_left;
            job_first_reg <= 1'b1;
            job_frame_reg <= push_flags.last_row && push_flags.last_col;
        end
        else if (job_fire)
        begin
            job_first_reg <= 1'b0;
            if (job_left_reg == 2'd0)
            begin
                job_valid_reg <= 1'b0;
            end
            else
            begin
                job_left_reg <= job_left_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            job_value_reg <= push_value;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= job_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_fire)
        begin
            out_px_reg    <= job_first_reg ? job_value_reg : '0;
            out_last_reg  <= (job_left_reg == 2'd0);
            out_frame_reg <= (job_left_reg == 2'd0) && job_frame_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.red_out   = out_px_reg[0 +: CHANNEL_BITS];
    assign result.green_out = out_px_reg[CHANNEL_BITS +: CHANNEL_BITS];
    assign result.blue_out  = out_px_reg[2*CHANNEL_BITS +: CHANNEL_BITS];
    assign result.run_last  = out_last_reg;
    assign result.frame_end = out_frame_reg;

    a_left_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid_reg |-> job_left_reg == 2'd0)
        else $error("result count left over with no item held");

    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_frame_reg) |-> out_last_reg)
        else $error("frame end on a result that does not close its item");

    a_corner_block: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && push_flags.last_row && push_flags.last_col) |=> !push_ready)
        else $error("new item taken while frame corner results are pending");

endmodule

// ----- sv/laplacian_edge_filter_3x3.sv -----
// Top level of the streaming 3x3 Laplacian edge filter.
//
// Pixels enter on the pixel channel in raster order, one item per valid/ready
// handshake; results leave on the result channel. Width and height are set
// through the write port (index 0 width, index 1 height); the user writes
// them only while the block is idle; the block does not enforce it. A write
// restarts the frame at the top-left pixel. Results for row y-1 leave while
// row y arrives. Border pixels are zero; the last input row also emits the
// final border row. run_last closes the results of one input item, frame_end
// marks the last result of the frame.
// Throughput: one item per cycle where an item yields one result and the
// receiver is ready. An item on the last column or in the last row yields
// two results, the last pixel of the frame four; the output register sends
// one result per cycle, so input waits there while the extra results leave.
// The line stores live in one memory with a registered read port: an item
// reads its column in the cycle it is accepted, writes it back as it leaves s1.
// Reset empties the pipeline, sets 640 x 480 and starts at the first pixel.
// When the receiver stalls, results hold and the pipeline fills; input then
// stalls after at most four items in flight.
module laplacian_edge_filter_3x3 import lef_pkg::*; #(
    parameter int MAX_LINE_WIDTH = LINE_WIDTH_DEFAULT,
    parameter int CHANNEL_BITS   = CHANNEL_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    lef_pixel_if.sink                 pixel,
    lef_result_if.source              result
);

    localparam int COL_BITS    = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int PXW         = 3 * CHANNEL_BITS;
    localparam int RESET_WIDTH = (WIDTH_RESET > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : WIDTH_RESET;

    logic [COL_BITS-1:0]        w_last_reg;
    logic [COL_BITS-1:0]        w_last_next;
    logic [ROW_BITS-1:0]        h_last_reg;
    logic [ROW_BITS-1:0]        h_last_next;
    logic [COL_BITS-1:0]        col_reg;
    logic [ROW_BITS-1:0]        row_reg;
    logic [WIDTH_REG_BITS-1:0]  w_raw;
    logic [HEIGHT_REG_BITS-1:0] h_raw;
    logic                       accept;
    pos_flags_t                 cur_flags;
    logic                       s1_valid_reg;
    logic                       s1_ready;
    logic [PXW-1:0]             s1_px_reg;
    logic [COL_BITS-1:0]        s1_addr_reg;
    pos_flags_t                 s1_flags_reg;
    logic                       mem_we;
    logic [2*PXW-1:0]           rd_data;
    logic                       push_valid;
    logic                       push_ready;
    logic [PXW-1:0]             push_value;
    pos_flags_t                 push_flags;

    assign accept      = pixel.valid && pixel.ready;
    assign pixel.ready = !s1_valid_reg || s1_ready;
    assign mem_we      = s1_valid_reg && s1_ready;

    // Clamp the written geometry and keep it as last index
    assign w_raw = cfg_data[WIDTH_REG_BITS-1:0];
    assign h_raw = cfg_data[HEIGHT_REG_BITS-1:0];

    always_comb
    begin
        priority if (w_raw < WIDTH_REG_BITS'(MIN_DIM))
        begin
            w_last_next = COL_BITS'(MIN_DIM - 1);
        end
        else if (int'(w_raw) > MAX_LINE_WIDTH)
        begin
            w_last_next = COL_BITS'(MAX_LINE_WIDTH - 1);
        end
        else
        begin
            w_last_next = COL_BITS'(w_raw - WIDTH_REG_BITS'(1));
        end

        priority if (h_raw < HEIGHT_REG_BITS'(MIN_DIM))
        begin
            h_last_next = ROW_BITS'(MIN_DIM - 1);
        end
        else if (int'(h_raw) > HEIGHT_LIMIT)
        begin
            h_last_next = ROW_BITS'(HEIGHT_LIMIT - 1);
        end
        else
        begin
            h_last_next = ROW_BITS'(h_raw - HEIGHT_REG_BITS'(1));
        end
    end

    // Position of the item now on the input
    always_comb
    begin
        cur_flags.emit     = (row_reg != '0) && (col_reg != '0);
        cur_flags.border   = (row_reg == ROW_BITS'(1)) || (col_reg == COL_BITS'(1));
        cur_flags.last_col = (col_reg == w_last_reg);
        cur_flags.last_row = (row_reg == h_last_reg);
    end

    // Geometry registers and raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= COL_BITS'(RESET_WIDTH - 1);
            h_last_reg <= ROW_BITS'(HEIGHT_RESET - 1);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    w_last_reg <= w_last_next;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                REG_IMAGE_HEIGHT:
                begin
                    h_last_reg <= h_last_next;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            if (cur_flags.last_col)
            begin
                col_reg <= '0;
                row_reg <= cur_flags.last_row ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_BITS'(1);
            end
        end
    end

    // Hold the item while its line store read returns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= {pixel.blue_in, pixel.green_in, pixel.red_in};
            s1_addr_reg  <= col_reg;
            s1_flags_reg <= cur_flags;
        end
    end

    // Upper line in the top half of an entry, middle line in the bottom half
    lef_line_mem #(
        .DEPTH     (MAX_LINE_WIDTH),
        .DATA_BITS (2 * PXW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (s1_addr_reg),
        .wr_data ({rd_data[PXW-1:0], s1_px_reg})
    );

    lef_window #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .s1_ready   (s1_ready),
        .s1_px      (s1_px_reg),
        .s1_flags   (s1_flags_reg),
        .up_px      (rd_data[2*PXW-1:PXW]),
        .mid_px     (rd_data[PXW-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_value (push_value),
        .push_flags (push_flags)
    );

    lef_emit #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_value (push_value),
        .push_flags (push_flags),
        .result     (result)
    );

    a_mem_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mem_we) |-> (col_reg != s1_addr_reg))
        else $error("line store read and write hit the same column");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last_reg)
        else $error("column counter beyond the line width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_last_reg)
        else $error("row counter beyond the frame height");

endmodule

// ----- sim/laplacian_edge_filter_3x3_tb.sv -----
// Self-checking testbench for the streaming 3x3 Laplacian edge filter.
module laplacian_edge_filter_3x3_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lef_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PERCENT  = 16;
    localparam int QUIET_PERIOD  = 2500;
    localparam int QUIET_SPAN    = 400;
    localparam int HOLD_CYCLES   = 120;
    localparam int HOLD_FIRST    = 100;
    localparam int HOLD_SPACING  = 900;
    localparam int HOLD_BACKLOG  = 6;
    localparam int WIDE_PIXELS   = 24;
    localparam int RANDOM_PIXELS = 340;
    localparam int LINE_CAP      = LINE_WIDTH_DEFAULT;
    localparam int CH            = CHANNEL_BITS_DEFAULT;
    localparam int CH_MAX        = (1 << CH) - 1;

    // Register indexes that decode to nothing
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = CFG_INDEX_BITS'(3);

    typedef logic [3*CH-1:0] rgb_t;   // blue, green, red from the top

    typedef struct packed {
        logic [CH-1:0] red;
        logic [CH-1:0] green;
        logic [CH-1:0] blue;
        logic          run_last;
        logic          frame_end;
    } edge_result_t;

    typedef enum int {TEXTURE_NOISE, TEXTURE_SMOOTH, TEXTURE_HARD} texture_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    lef_pixel_if  #(.CHANNEL_BITS(CH)) pix ();
    lef_result_if #(.CHANNEL_BITS(CH)) res ();

    laplacian_edge_filter_3x3 #(
        .MAX_LINE_WIDTH (LINE_CAP),
        .CHANNEL_BITS   (CH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pix),
        .result    (res)
    );

    // Filter state as the stream sees it
    rgb_t        upper_line [LINE_CAP];
    rgb_t        middle_line [LINE_CAP];
    rgb_t        window_px [9];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned reg_width;
    int unsigned reg_height;

    edge_result_t edge_results_due [$];
    rgb_t         pixels_to_send [$];
    int           pixels_fed   = 0;
    int           pixels_taken = 0;
    int           error_count  = 0;
    int           cycle_count  = 0;
    int           hold_left    = 0;
    int           next_hold_at = HOLD_FIRST;
    logic         quiet;

    // Stretches with no random idling on either side
    assign quiet = (cycle_count % QUIET_PERIOD) < QUIET_SPAN;

    always #(CLK_PERIOD/2) clk = ~clk;

    function automatic rgb_t rgb(int red, int green, int blue);
        return {blue[CH-1:0], green[CH-1:0], red[CH-1:0]};
    endfunction

    function automatic int unsigned clamp_width();
        if (reg_width < MIN_DIM)
            return MIN_DIM;
        if (reg_width > LINE_CAP)
            return LINE_CAP;
        return reg_width;
    endfunction

    function automatic int unsigned clamp_height();
        if (reg_height < MIN_DIM)
            return MIN_DIM;
        if (reg_height > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        return reg_height;
    endfunction

    // Eight times the centre minus the ring, per channel, clamped
    function automatic rgb_t window_laplacian();
        rgb_t lap;
        int   acc;
        lap = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 8 * int'(window_px[4][ch*CH +: CH]);
            for (int k = 0; k < 9; k++)
            begin
                if (k != 4)
                    acc -= int'(window_px[k][ch*CH +: CH]);
            end
            if (acc < 0)
                acc = 0;
            if (acc > CH_MAX)
                acc = CH_MAX;
            lap[ch*CH +: CH] = acc[CH-1:0];
        end
        return lap;
    endfunction

    function automatic edge_result_t edge_result(rgb_t px);
        edge_result_t out;
        out.red       = px[CH-1:0];
        out.green     = px[2*CH-1:CH];
        out.blue      = px[3*CH-1:2*CH];
        out.run_last  = 1'b0;
        out.frame_end = 1'b0;
        return out;
    endfunction

    // Advance the filter state by one pixel and queue the results it causes
    task automatic compute_edge_results(input rgb_t px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        int unsigned  a;
        rgb_t         up_px;
        rgb_t         mid_px;
        logic         last_col;
        logic         last_row;
        edge_result_t outs [4];
        int           n;
        w = clamp_width();
        h = clamp_height();
        c = col_pos;
        r = row_pos;
        a = (c < LINE_CAP) ? c : 0;
        n = 0;
        up_px  = upper_line[a];
        mid_px = middle_line[a];
        for (int i = 0; i < 3; i++)
        begin
            window_px[i*3]     = window_px[i*3 + 1];
            window_px[i*3 + 1] = window_px[i*3 + 2];
        end
        window_px[2]   = up_px;
        window_px[5]   = mid_px;
        window_px[8]   = px;
        upper_line[a]  = mid_px;
        middle_line[a] = px;
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);

        // Centre of the previous row, then the closing border pixels
        if (r >= 1 && c >= 1)
        begin
            outs[n] = edge_result((r == 1 || c == 1) ? '0 : window_laplacian());
            n = n + 1;
            if (last_row)
            begin
                outs[n] = edge_result('0);
                n = n + 1;
            end
            if (last_col)
            begin
                outs[n] = edge_result('0);
                n = n + 1;
                if (last_row)
                begin
                    outs[n] = edge_result('0);
                    n = n + 1;
                end
            end
            outs[n-1].run_last = 1'b1;
            outs[n-1].frame_end = last_row && last_col;
            for (int i = 0; i < n; i++)
                edge_results_due.push_back(outs[i]);
        end

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((r + 1) & ((1 << ROW_BITS) - 1));
        end
        else
            col_pos = (c + 1) & (LINE_CAP - 1);
    endtask

    function automatic rgb_t textured_pixel(texture_t tex, rgb_t base);
        rgb_t px;
        int   v;
        px = '0;
        case (tex)
            TEXTURE_SMOOTH:
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    v = int'(base[ch*CH +: CH]) + int'($urandom_range(0, 30)) - 15;
                    if (v < 0)
                        v = 0;
                    if (v > CH_MAX)
                        v = CH_MAX;
                    px[ch*CH +: CH] = v[CH-1:0];
                end
            end
            TEXTURE_HARD:
            begin
                for (int ch = 0; ch < 3; ch++)
                    px[ch*CH +: CH] = $urandom_range(0, 1) ? '1 : '0;
            end
            default:
                px = rgb_t'($urandom);
        endcase
        return px;
    endfunction

    task automatic queue_pixel(input rgb_t px);
        pixels_to_send.push_back(px);
        pixels_fed++;
    endtask

    task automatic queue_textured_pixels(input int count, input texture_t tex);
        rgb_t base;
        base = rgb_t'($urandom);
        for (int i = 0; i < count; i++)
            queue_pixel(textured_pixel(tex, base));
    endtask

    // Part of a 3x3 frame: one centre pixel inside a uniform ring
    task automatic queue_ringed_frame(input rgb_t ring, input rgb_t centre,
                                      input int first, input int last);
        for (int i = first; i <= last; i++)
            queue_pixel((i == 4) ? centre : ring);
    endtask

    // Hold until every item is taken and every result is back, then settle
    task automatic drain_pipeline();
        while (pixels_taken != pixels_fed || edge_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; a real register restarts the frame
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT)
        begin
            if (idx == REG_IMAGE_WIDTH)
                reg_width = value[WIDTH_REG_BITS-1:0];
            else
                reg_height = value[HEIGHT_REG_BITS-1:0];
            col_pos = 0;
            row_pos = 0;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Pixel driver: predict on every accepted item, then offer the next
    always @(posedge clk)
    begin
        rgb_t next_px;
        if (!rst_n)
            pix.valid <= 1'b0;
        else
        begin
            if (pix.valid && pix.ready)
            begin
                compute_edge_results({pix.blue_in, pix.green_in, pix.red_in});
                pixels_taken <= pixels_taken + 1;
            end
            if (!pix.valid || pix.ready)
            begin
                if (pixels_to_send.size() != 0
                    && (quiet || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    next_px = pixels_to_send.pop_front();
                    pix.valid    <= 1'b1;
                    pix.red_in   <= next_px[CH-1:0];
                    pix.green_in <= next_px[2*CH-1:CH];
                    pix.blue_in  <= next_px[3*CH-1:2*CH];
                end
                else
                    pix.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus long hold-offs that back up the input;
    // a hold-off starts only while results are due and more items wait to be sent
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            res.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (pixels_taken >= next_hold_at && edge_results_due.size() != 0
                 && pixels_to_send.size() >= HOLD_BACKLOG)
        begin
            res.ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_SPACING;
        end
        else
            res.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        edge_result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (edge_results_due.size() == 0)
            begin
                $error("unexpected result: red %0d green %0d blue %0d",
                       res.red_out, res.green_out, res.blue_out);
                error_count++;
            end
            else
            begin
                want = edge_results_due.pop_front();
                if (res.red_out !== want.red)
                begin
                    $error("red_out: expected %0d, got %0d", want.red, res.red_out);
                    error_count++;
                end
                if (res.green_out !== want.green)
                begin
                    $error("green_out: expected %0d, got %0d", want.green, res.green_out);
                    error_count++;
                end
                if (res.blue_out !== want.blue)
                begin
                    $error("blue_out: expected %0d, got %0d", want.blue, res.blue_out);
                    error_count++;
                end
                if (res.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0d, got %0d", want.run_last, res.run_last);
                    error_count++;
                end
                if (res.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0d, got %0d", want.frame_end, res.frame_end);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, edge_results_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        int unsigned w_cfg;
        int unsigned h_cfg;
        int          frames;
        int          total;
        int          count;
        int          random_sent;
        texture_t    tex;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_IMAGE_WIDTH;
        cfg_data     = '0;
        pix.valid    = 1'b0;
        pix.red_in   = '0;
        pix.green_in = '0;
        pix.blue_in  = '0;
        res.ready    = 1'b0;
        random_sent  = 0;

        // Filter state after reset
        for (int i = 0; i < LINE_CAP; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            window_px[i] = '0;
        col_pos    = 0;
        row_pos    = 0;
        reg_width  = WIDTH_RESET;
        reg_height = HEIGHT_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // First row of the reset geometry gives nothing; a write then restarts
        queue_pixel(rgb(CH_MAX, CH_MAX, CH_MAX));
        queue_pixel(rgb(0, 0, 0));
        queue_pixel(rgb(8'hAA, 8'h55, 8'hF0));
        drain_pipeline();

        // Smallest frame: bright red centre, level green step, dark blue centre
        write_register(REG_IMAGE_WIDTH, MIN_DIM);
        write_register(REG_IMAGE_HEIGHT, MIN_DIM);
        queue_ringed_frame(rgb(0, 10, CH_MAX), rgb(CH_MAX, 20, 0), 0, 8);
        drain_pipeline();

        // Below-range sizes clamp to 3x3; a spare index mid-frame is ignored
        write_register(REG_IMAGE_WIDTH, 0);
        write_register(REG_IMAGE_HEIGHT, 2);
        queue_ringed_frame(rgb(CH_MAX, 0, 190), rgb(0, CH_MAX, 200), 0, 3);
        drain_pipeline();
        write_register(REG_SPARE_2, 13'h1FFF);
        queue_ringed_frame(rgb(CH_MAX, 0, 190), rgb(0, CH_MAX, 200), 4, 8);
        drain_pipeline();
        write_register(REG_SPARE_3, 13'h0AAA);

        // Widest line: the start of its first row, cut short
        write_register(REG_IMAGE_WIDTH, 13'h1FFF);
        write_register(REG_IMAGE_HEIGHT, HEIGHT_LIMIT);
        queue_textured_pixels(WIDE_PIXELS, TEXTURE_SMOOTH);
        drain_pipeline();

        // Random geometries, mostly whole frames, some cut short
        while (random_sent < RANDOM_PIXELS)
        begin
            pick = $urandom_range(0, 11);
            if (pick == 0)
            begin
                w_cfg = $urandom_range(0, (1 << CFG_DATA_BITS) - 1);
                h_cfg = $urandom_range(0, (1 << CFG_DATA_BITS) - 1);
            end
            else
            begin
                w_cfg = (pick == 1) ? $urandom_range(0, MIN_DIM - 1) : $urandom_range(MIN_DIM, 9);
                if (pick == 2)
                    h_cfg = $urandom_range(0, MIN_DIM - 1);
                else if (pick == 3)
                    h_cfg = $urandom_range(HEIGHT_LIMIT, (1 << CFG_DATA_BITS) - 1);
                else
                    h_cfg = $urandom_range(MIN_DIM, 6);
            end
            if ($urandom_range(0, 1))
            begin
                write_register(REG_IMAGE_WIDTH, w_cfg);
                write_register(REG_IMAGE_HEIGHT, h_cfg);
            end
            else
            begin
                write_register(REG_IMAGE_HEIGHT, h_cfg);
                write_register(REG_IMAGE_WIDTH, w_cfg);
            end

            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames; f++)
            begin
                total = clamp_width() * clamp_height();
                if (total > 60)
                    count = $urandom_range(10, 60);
                else if ($urandom_range(0, 5) == 0)
                    count = $urandom_range(1, total - 1);
                else
                    count = total;
                tex = texture_t'($urandom_range(0, 2));
                queue_textured_pixels(count, tex);
                random_sent += count;
                if (count < total)
                    break;
            end
            drain_pipeline();
        end

        drain_pipeline();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
